FILE: sv/fcpw_pkg.sv
// Shared constants and types for the four-channel pulse width capture block.
`timescale 1ns / 1ps

package fcpw_pkg;

  localparam int CHANNELS = 4;
  localparam int OUT_CH   = 4;
  localparam int WRAP_LIMIT = 16383;

  localparam int CMD_W    = 2;
  localparam int CHAN_W   = 2;
  localparam int VALUE_W  = 16;
  localparam int COUNT_W  = 14;
  localparam int WIDTH_W  = 30;
  localparam int PERIOD_W = 16;
  localparam int PROD_W   = COUNT_W + PERIOD_W + 1;
  localparam int TOTAL_W  = PROD_W + 1;

  localparam logic [CMD_W-1:0] CMD_WRAP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EDGE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  localparam logic [COUNT_W-1:0]  WRAP_LIMIT_C = COUNT_W'(WRAP_LIMIT);
  localparam logic [VALUE_W-1:0]  END_FORCED   = 16'hFFFF;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'hFFFF;
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = 30'h3FFF_FFFF;

  // One channel's snapshot, taken when a read is accepted.
  typedef struct packed {
    logic               done;
    logic               wraps_nz;
    logic [PROD_W-1:0]  prod;
    logic [VALUE_W-1:0] start;
    logic [VALUE_W-1:0] stop;
  } lane_t;

endpackage

FILE: sv/four_channel_pulse_width_capture.sv
// Top level: four-channel high pulse width capture with a two-stage read path.
//
// Channel  | Direction | Beat content
// in_      | slave     | tuser = command, channel; tdata = capture_value
// out_     | master    | tdata = width_ch0..width_ch3; tuser = any_new
// cfg_     | write     | wr_data = wrap_period
//
// One beat is taken per cycle while in_tready is high. Wrap ticks and edges update the
// channel registers at the accepting edge. A read snapshots the channels and multiplies
// the wrap counts by wrap_period + 1 in the first stage, then subtracts and saturates
// into the output register. Reset (rst_n low, synchronous) clears the channel registers
// and widths and sets wrap_period to 65535; the snapshot lanes are not reset. A stalled
// output holds its beat; one further read can wait in the first stage before in_tready drops.
`timescale 1ns / 1ps

module four_channel_pulse_width_capture (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [3:0]   in_tuser,   // [1:0] command, [3:2] channel
  input  logic [15:0]  in_tdata,   // [15:0] capture_value
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // width_ch0, width_ch1, width_ch2, width_ch3, 30 bits each
  output logic         out_tuser,  // [0] any_new
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data // wrap_period
);

  localparam int CH  = fcpw_pkg::CHANNELS;
  localparam int VW  = fcpw_pkg::VALUE_W;
  localparam int CW  = fcpw_pkg::COUNT_W;
  localparam int WW  = fcpw_pkg::WIDTH_W;
  localparam int PW  = fcpw_pkg::PROD_W;
  localparam int TW  = fcpw_pkg::TOTAL_W;

  logic [fcpw_pkg::PERIOD_W-1:0] period_r;

  logic [CH-1:0] armed_r, armed_nxt;
  logic [CH-1:0] done_r, done_nxt;
  logic [CW-1:0] count_r [CH];
  logic [CW-1:0] count_nxt [CH];
  logic [VW-1:0] start_r [CH];
  logic [VW-1:0] start_nxt [CH];
  logic [VW-1:0] stop_r [CH];
  logic [VW-1:0] stop_nxt [CH];
  logic [WW-1:0] last_width_r [CH];
  logic [WW-1:0] last_width_nxt [CH];

  fcpw_pkg::lane_t lane_r [CH];
  fcpw_pkg::lane_t lane_nxt [CH];
  logic            s1_v_r;
  logic            s1_adv;
  logic            any_r;
  logic            any_nxt;
  logic            out_v_r;

  logic [fcpw_pkg::CMD_W-1:0]  cmd;
  logic [fcpw_pkg::CHAN_W-1:0] chan;
  logic                        accept;
  logic                        take_read;

  assign cmd       = in_tuser[1:0];
  assign chan      = in_tuser[3:2];
  assign s1_adv    = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_adv;
  assign accept    = in_tvalid && in_tready;
  assign take_read = accept && (cmd == fcpw_pkg::CMD_READ);

  // Channel register updates for wrap ticks, edges and reads.
  always_comb begin
    logic [PW-1:0] period_p1;
    period_p1 = PW'(period_r) + PW'(1);
    armed_nxt = armed_r;
    done_nxt  = done_r;
    for (int c = 0; c < CH; c++) begin
      count_nxt[c]    = count_r[c];
      start_nxt[c]    = start_r[c];
      stop_nxt[c]     = stop_r[c];
      lane_nxt[c].done     = done_r[c];
      lane_nxt[c].wraps_nz = (count_r[c] != '0);
      lane_nxt[c].prod     = PW'(count_r[c]) * period_p1;
      lane_nxt[c].start    = start_r[c];
      lane_nxt[c].stop     = stop_r[c];
    end
    if (accept) begin
      case (cmd)
        fcpw_pkg::CMD_WRAP: begin
          for (int c = 0; c < CH; c++) begin
            if (armed_r[c] && !done_r[c]) begin
              if (count_r[c] >= fcpw_pkg::WRAP_LIMIT_C) begin
                done_nxt[c] = 1'b1;
                stop_nxt[c] = fcpw_pkg::END_FORCED;
              end else begin
                count_nxt[c] = count_r[c] + CW'(1);
              end
            end
          end
        end
        fcpw_pkg::CMD_EDGE: begin
          for (int c = 0; c < CH; c++) begin
            if (32'(chan) == c) begin
              if (armed_r[c]) begin
                stop_nxt[c] = in_tdata;
                done_nxt[c] = 1'b1;
              end else begin
                start_nxt[c] = in_tdata;
                count_nxt[c] = '0;
                done_nxt[c]  = 1'b0;
                armed_nxt[c] = 1'b1;
              end
            end
          end
        end
        fcpw_pkg::CMD_READ: begin
          armed_nxt = '0;
          done_nxt  = '0;
          for (int c = 0; c < CH; c++) begin
            count_nxt[c] = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Width of each snapshot lane; lanes that were not done keep their last width.
  always_comb begin
    logic [TW-1:0] total;
    logic [TW-1:0] wide;
    logic [VW-1:0] diff;
    any_nxt = 1'b0;
    for (int c = 0; c < CH; c++) begin
      total = TW'(lane_r[c].prod) + TW'(lane_r[c].stop);
      diff  = (lane_r[c].stop >= lane_r[c].start) ? lane_r[c].stop - lane_r[c].start
                                                  : lane_r[c].start - lane_r[c].stop;
      if (lane_r[c].wraps_nz) begin
        wide = (total >= TW'(lane_r[c].start)) ? total - TW'(lane_r[c].start) : '0;
      end else begin
        wide = TW'(diff);
      end
      if (!lane_r[c].done) begin
        last_width_nxt[c] = last_width_r[c];
      end else if (wide > TW'(fcpw_pkg::WIDTH_MAX)) begin
        last_width_nxt[c] = fcpw_pkg::WIDTH_MAX;
      end else begin
        last_width_nxt[c] = wide[WW-1:0];
      end
      if (lane_r[c].done) begin
        any_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= fcpw_pkg::PERIOD_RESET;
      armed_r  <= '0;
      done_r   <= '0;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      any_r    <= 1'b0;
      for (int c = 0; c < CH; c++) begin
        count_r[c]      <= '0;
        start_r[c]      <= '0;
        stop_r[c]       <= '0;
        last_width_r[c] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        period_r <= cfg_wr_data;
      end
      armed_r <= armed_nxt;
      done_r  <= done_nxt;
      for (int c = 0; c < CH; c++) begin
        count_r[c] <= count_nxt[c];
        start_r[c] <= start_nxt[c];
        stop_r[c]  <= stop_nxt[c];
      end
      if (take_read) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_v_r && s1_adv) begin
        out_v_r <= 1'b1;
        any_r   <= any_nxt;
        for (int c = 0; c < CH; c++) begin
          last_width_r[c] <= last_width_nxt[c];
        end
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Snapshot lanes are payload only; they load with each accepted read beat.
  always_ff @(posedge clk) begin
    if (take_read) begin
      for (int c = 0; c < CH; c++) begin
        lane_r[c] <= lane_nxt[c];
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = any_r;

  for (genvar k = 0; k < fcpw_pkg::OUT_CH; k++) begin : g_out
    if (k < CH) begin : g_used
      assign out_tdata[k*WW +: WW] = last_width_r[k];
    end else begin : g_absent
      assign out_tdata[k*WW +: WW] = '0;
    end
  end

endmodule

FILE: sv/fcpw_checker.sv
// Port-level checker for the pulse width capture block, bound to the top level.
`timescale 1ns / 1ps

module fcpw_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [3:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [119:0] out_tdata,
  input logic         out_tuser
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // With the output register empty, the read stage can always drain.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output");

  // A read taken with an empty output goes via the read stage to out_tvalid.
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[1:0] == fcpw_pkg::CMD_READ) && !out_tvalid
      |-> ##2 out_tvalid)
    else $error("read result missing");

endmodule

bind four_channel_pulse_width_capture fcpw_checker u_fcpw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
